// ===== rtl/atd_pkg.sv =====
// Shared types and constants for the tilt angle to duty block.
package atd_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int CORDIC_STEPS = 17;
  localparam int TILT_MAX = 90;

  // degrees = floor(ang * 9000 / (157 * 2^16)), by reciprocal and one correction
  localparam int DEG_MUL = 9000;
  localparam longint DEG_DIV = 157 * 65536;
  localparam int RECIP_SHIFT = 40;
  localparam longint DEG_RECIP = (64'd1 << RECIP_SHIFT) / DEG_DIV;

  // configuration register indexes
  localparam logic [7:0] REG_DUTY_TOP = 8'd0;
  localparam logic [7:0] REG_DUTY_STEP = 8'd1;

  localparam logic [15:0] DUTY_TOP_RST = 16'd7119;
  localparam logic [7:0] DUTY_STEP_RST = 8'd10;

  // atan(2^-i) in Q16 radians
  localparam logic [16:0] ATAN_Q16 [CORDIC_STEPS] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
    17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
    17'd8, 17'd4, 17'd2, 17'd1
  };

  typedef struct packed {
    logic szero;  // x and y both zero
    logic zzero;  // z zero
    logic zneg;   // z negative
  } atd_flag_t;

  typedef struct packed {
    logic        vld;
    atd_flag_t   flg;
    logic [15:0] az;
    logic [35:0] rem;
    logic [31:0] root;
    logic [31:0] rad;
  } atd_sq_t;

  typedef struct packed {
    logic               vld;
    atd_flag_t          flg;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [17:0] ang;
  } atd_cr_t;

endpackage

// ===== rtl/accel_tilt_angle_to_duty.sv =====
// Top level: pipelined tilt angle and PWM compare value from one accelerometer sample.
//
// One request (acc_x, acc_y, acc_z) enters per clock while in_stall is low, and each
// gives exactly one result (tilt_degrees, duty_compare) in the output register. The
// path is two squaring stages, a 32-stage bit-per-stage square root of
// (x^2 + y^2) * 2^32, a 17-stage CORDIC vectoring unit that takes the angle of
// (|z|, root), and six stages that turn the Q16 radian angle into whole degrees
// (scaled by 180/3.14, truncated, limited to 90, signed by z) and form duty_top -
// duty_step * tilt (a negative tilt counts as zero), saturated at zero. The whole
// pipeline advances on one enable; a two-entry output buffer (output register plus
// skid register) lets the pipeline keep taking requests while a result waits, and
// in_stall rises only once both entries are full. Sustained rate is one request per
// cycle when out_stall stays low. A zero x/y magnitude gives tilt 0; z equal to
// zero otherwise gives tilt 90. Write duty_top (index 0) and duty_step (index 1)
// only while no request is in flight; cfg_ready is always high and other indexes
// are dropped.
module accel_tilt_angle_to_duty (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic signed [15:0] acc_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  tilt_degrees,
  output logic [15:0]        duty_compare,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import atd_pkg::*;

  // configuration registers
  logic [15:0] duty_top;
  logic [7:0]  duty_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_top  <= DUTY_TOP_RST;
      duty_step <= DUTY_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DUTY_TOP:  duty_top  <= cfg_data;
        REG_DUTY_STEP: duty_step <= cfg_data[7:0];
        default:       ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Global advance: the pipeline moves whenever the skid register is free.
  logic en;
  logic skid_vld;
  assign en       = !skid_vld;
  assign in_stall = skid_vld;

  // Stage A: squares, |z| and z flags
  logic signed [31:0] sq_x, sq_y;
  logic               a_vld;
  logic [30:0]        a_xx, a_yy;
  logic [15:0]        a_az;
  logic               a_zzero, a_zneg;

  assign sq_x = 32'(acc_x) * 32'(acc_x);
  assign sq_y = 32'(acc_y) * 32'(acc_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld   <= in_valid;
      a_xx    <= sq_x[30:0];
      a_yy    <= sq_y[30:0];
      a_az    <= acc_z[15] ? (~acc_z + 16'd1) : acc_z;
      a_zzero <= (acc_z == 16'sd0);
      a_zneg  <= acc_z[15];
    end
  end

  // Stage B: sum of squares loads the square root pipeline
  atd_sq_t     sq [SQRT_STEPS+1];
  logic [31:0] sum_xy;

  assign sum_xy = {1'b0, a_xx} + {1'b0, a_yy};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].vld <= 1'b0;
    end else if (en) begin
      sq[0].vld       <= a_vld;
      sq[0].flg.szero <= (sum_xy == 32'd0);
      sq[0].flg.zzero <= a_zzero;
      sq[0].flg.zneg  <= a_zneg;
      sq[0].az        <= a_az;
      sq[0].rem       <= '0;
      sq[0].root      <= '0;
      sq[0].rad       <= sum_xy;
    end
  end

  // Square root, one result bit per stage. The radicand is sum_xy * 2^32, so the
  // low 16 digit pairs come in as zeros once rad has shifted empty.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [35:0] cur;
    logic [35:0] trial;
    logic        take;

    assign cur   = {sq[k].rem[33:0], sq[k].rad[31:30]};
    assign trial = {2'b00, sq[k].root, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k+1].vld <= 1'b0;
      end else if (en) begin
        sq[k+1].vld  <= sq[k].vld;
        sq[k+1].flg  <= sq[k].flg;
        sq[k+1].az   <= sq[k].az;
        sq[k+1].rem  <= take ? (cur - trial) : cur;
        sq[k+1].root <= {sq[k].root[30:0], take};
        sq[k+1].rad  <= {sq[k].rad[29:0], 2'b00};
      end
    end
  end

  // CORDIC vectoring on (|z| in Q16, root)
  atd_cr_t cr [CORDIC_STEPS+1];

  always_comb begin
    cr[0].vld = sq[SQRT_STEPS].vld;
    cr[0].flg = sq[SQRT_STEPS].flg;
    cr[0].cx  = signed'({4'b0000, sq[SQRT_STEPS].az, 16'h0000});
    cr[0].cy  = signed'({4'b0000, sq[SQRT_STEPS].root});
    cr[0].ang = '0;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [35:0] dx, dy;
    logic signed [17:0] da;

    assign dx = cr[k].cy >>> k;
    assign dy = cr[k].cx >>> k;
    assign da = signed'({1'b0, ATAN_Q16[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        cr[k+1].vld <= 1'b0;
      end else if (en) begin
        cr[k+1].vld <= cr[k].vld;
        cr[k+1].flg <= cr[k].flg;
        if (!cr[k].cy[35]) begin
          cr[k+1].cx  <= cr[k].cx + dx;
          cr[k+1].cy  <= cr[k].cy - dy;
          cr[k+1].ang <= cr[k].ang + da;
        end else begin
          cr[k+1].cx  <= cr[k].cx - dx;
          cr[k+1].cy  <= cr[k].cy + dy;
          cr[k+1].ang <= cr[k].ang - da;
        end
      end
    end
  end

  // Stage P: clamp negative angle to zero, scale by 9000
  atd_cr_t     cr_out;
  logic [16:0] ang_pos;
  logic [29:0] ang_scaled;
  logic        p_vld;
  atd_flag_t   p_flg;
  logic [29:0] p_num;

  assign cr_out     = cr[CORDIC_STEPS];
  assign ang_pos    = cr_out.ang[17] ? 17'd0 : cr_out.ang[16:0];
  assign ang_scaled = 30'(ang_pos * 14'(DEG_MUL));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= cr_out.vld;
      p_flg <= cr_out.flg;
      p_num <= ang_scaled;
    end
  end

  // Stage Q: quotient estimate by reciprocal, low by at most one
  logic [46:0] q_est;
  logic        q_vld;
  atd_flag_t   q_flg;
  logic [29:0] q_num;
  logic [6:0]  q_quo;

  assign q_est = 47'(p_num * 17'(DEG_RECIP));

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else if (en) begin
      q_vld <= p_vld;
      q_flg <= p_flg;
      q_num <= p_num;
      q_quo <= q_est[RECIP_SHIFT+6:RECIP_SHIFT];
    end
  end

  // Stage C: back-multiply the estimate
  logic        c_vld;
  atd_flag_t   c_flg;
  logic [29:0] c_num;
  logic [6:0]  c_quo;
  logic [29:0] c_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld  <= q_vld;
      c_flg  <= q_flg;
      c_num  <= q_num;
      c_quo  <= q_quo;
      c_back <= 30'(q_quo * 24'(DEG_DIV));
    end
  end

  // Stage D: correct the quotient, limit, apply special cases and sign
  logic [29:0]       c_rem;
  logic [7:0]        deg_fix;
  logic [6:0]        deg_mag;
  logic signed [7:0] tilt_next;
  logic              d_vld;
  logic signed [7:0] d_tilt;

  assign c_rem   = c_num - c_back;
  assign deg_fix = {1'b0, c_quo} + ((c_rem >= 30'(DEG_DIV)) ? 8'd1 : 8'd0);
  assign deg_mag = (deg_fix > 8'(TILT_MAX)) ? 7'(TILT_MAX) : deg_fix[6:0];

  always_comb begin
    if (c_flg.szero) begin
      tilt_next = 8'sd0;
    end else if (c_flg.zzero) begin
      tilt_next = 8'(TILT_MAX);
    end else if (c_flg.zneg) begin
      tilt_next = -signed'({1'b0, deg_mag});
    end else begin
      tilt_next = signed'({1'b0, deg_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld  <= c_vld;
      d_tilt <= tilt_next;
    end
  end

  // Stage E: step times positive tilt
  logic [6:0]        tilt_pos;
  logic              e_vld;
  logic signed [7:0] e_tilt;
  logic [14:0]       e_dec;

  assign tilt_pos = (d_tilt > 8'sd0) ? d_tilt[6:0] : 7'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld  <= d_vld;
      e_tilt <= d_tilt;
      e_dec  <= {7'd0, duty_step} * {8'd0, tilt_pos};
    end
  end

  // Stage F: subtract from top, saturate at zero
  logic [16:0]       duty_diff;
  logic              f_vld;
  logic signed [7:0] f_tilt;
  logic [15:0]       f_duty;

  assign duty_diff = {1'b0, duty_top} - {2'b00, e_dec};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld  <= e_vld;
      f_tilt <= e_tilt;
      f_duty <= duty_diff[16] ? 16'd0 : duty_diff[15:0];
    end
  end

  // Output register and skid register
  logic              out_take;
  logic signed [7:0] skid_tilt;
  logic [15:0]       skid_duty;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_vld) begin
        // drain the skid register first to keep order
        out_valid    <= 1'b1;
        tilt_degrees <= skid_tilt;
        duty_compare <= skid_duty;
        skid_vld     <= 1'b0;
      end else begin
        out_valid    <= f_vld;
        tilt_degrees <= f_tilt;
        duty_compare <= f_duty;
      end
    end else if (f_vld && en) begin
      // output held: park the result leaving the pipeline
      skid_vld  <= 1'b1;
      skid_tilt <= f_tilt;
      skid_duty <= f_duty;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tilt_degrees <= 8'sd90) && (tilt_degrees >= -8'sd90))
    else $error("tilt result out of range");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_vld && !out_stall |=> !skid_vld)
    else $error("skid register did not drain after output was taken");
`endif

endmodule
